>>> rtl/feas_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the flash erase area sequencer.
// No dependencies; every other file of the block uses this package.
package feas_pkg;

    localparam int ADDR_W = 32;
    localparam int SS_W   = 17;
    localparam int BS_W   = 25;
    localparam int KIND_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W  = $clog2(ADDR_W);

    // register reset values
    localparam logic [ADDR_W-1:0] CHIP_SIZE_RST   = 32'd16777216;
    localparam logic [SS_W-1:0]   SECTOR_SIZE_RST = 17'd4096;
    localparam logic [BS_W-1:0]   BLOCK_SIZE_RST  = 25'd65536;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd2;

    // operation codes of an input beat
    localparam logic OPER_REQUEST = 1'b0;
    localparam logic OPER_ACK     = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_UNLOCK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SECTOR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BLOCK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR    = 3'd4;

    // datapath register operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SEC    = 3'd2;
    localparam logic [OP_W-1:0] OP_SPB    = 3'd3;
    localparam logic [OP_W-1:0] OP_TOTAL  = 3'd4;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd5;
    localparam logic [OP_W-1:0] OP_COMMIT = 3'd6;

    // divider operand selects
    localparam int DSEL_W = 3;
    localparam logic [DSEL_W-1:0] DSEL_START = 3'd0;
    localparam logic [DSEL_W-1:0] DSEL_SPB   = 3'd1;
    localparam logic [DSEL_W-1:0] DSEL_LEN   = 3'd2;
    localparam logic [DSEL_W-1:0] DSEL_HEAD  = 3'd3;
    localparam logic [DSEL_W-1:0] DSEL_BLK   = 3'd4;

    typedef struct packed {
        logic                operation;
        logic [ADDR_W-1:0]   base_addr;
        logic [ADDR_W-1:0]   erase_len;
        logic                ack_ok;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   target_index;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [KIND_W-1:0]   kind;
        logic                div_go;
        logic [DSEL_W-1:0]   div_sel;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_ack;
        logic job_busy;
        logic ack_ok;
        logic range_err;
        logic ss_zero;
        logic div_done;
        logic rem_nz;
        logic quot_zero;
        logic head_nz;
        logic rest_gt_spb;
        logic rest_nz;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/flash_erase_area_sequencer_top.sv
`timescale 1ns / 1ps
// Flash erase area sequencer, top level: controller plus datapath.
// Depends on feas_pkg, feas_ctrl, feas_dpath (which holds feas_div).
//
// One beat is taken at a time. An acknowledgement beat that arrives while a
// job runs puts its result on the output (when it erases a whole block, the
// block number comes from the divider); one with no job running gives no
// result. An erase request runs up to four divisions on one shared divider
// that makes one quotient bit per cycle; a valid request runs all four. The
// next beat is accepted right after the result is loaded into the output
// register, even while that result is still stalled.
module flash_erase_area_sequencer_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [feas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [feas_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  feas_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output feas_pkg::out_item_t               out_data
);

    feas_pkg::cmd_t cmd;
    feas_pkg::sts_t sts;

    feas_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    feas_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> rtl/feas_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle, quotient and remainder held.
// Depends on feas_pkg.
module feas_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [feas_pkg::ADDR_W-1:0]   dividend,
    input  logic [feas_pkg::ADDR_W-1:0]   divisor,
    output logic                          done,
    output logic [feas_pkg::ADDR_W-1:0]   quot,
    output logic [feas_pkg::ADDR_W-1:0]   rem
);

    localparam int W = feas_pkg::ADDR_W;
    localparam logic [feas_pkg::CNT_W-1:0] LAST = feas_pkg::CNT_W'(W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [feas_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [W-1:0]                  quot_reg, quot_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  dsr_reg, dsr_next;
    logic [W:0]                    shifted;
    logic [W:0]                    diff;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // no borrow: divisor fits, keep the difference
            if (!diff[W])
            begin
                rem_next  = diff[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

>>> rtl/feas_dpath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, job registers, shared divider and output register.
// Depends on feas_pkg and feas_div.
module feas_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [feas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [feas_pkg::ADDR_W-1:0]       cfg_data,
    input  feas_pkg::in_item_t                in_data,
    input  logic                              out_stall,
    output logic                              out_valid,
    output feas_pkg::out_item_t               out_data,
    input  feas_pkg::cmd_t                    cmd,
    output feas_pkg::sts_t                    sts
);

    localparam int AW = feas_pkg::ADDR_W;
    localparam int SW = feas_pkg::SS_W;
    localparam int BW = feas_pkg::BS_W;

    // configuration
    logic [AW-1:0] chip_reg;
    logic [SW-1:0] ss_reg;
    logic [BW-1:0] bs_reg;

    // captured beat
    logic          oper_reg;
    logic [AW-1:0] start_reg;
    logic [AW-1:0] len_reg;
    logic          ok_reg;

    // job state
    logic          phase_reg, phase_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [BW-1:0] head_reg, head_next;
    logic [AW-1:0] rest_reg, rest_next;
    logic [BW-1:0] spb_reg, spb_next;
    logic [AW-1:0] sec_reg, sec_next;
    logic [AW-1:0] total_reg, total_next;

    logic                      oval_reg, oval_next;
    feas_pkg::out_item_t       odata_reg, odata_next;

    logic [AW-1:0] div_a, div_b, div_q, div_r;
    logic          div_done;
    logic [AW-1:0] spb_ext, sum, head_raw;
    logic          rem_nz;

    feas_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign spb_ext  = {{(AW-BW){1'b0}}, spb_reg};
    assign sum      = start_reg + len_reg;
    assign rem_nz   = (div_r != '0);
    assign head_raw = spb_ext - div_r;

    always_comb
    begin
        case (cmd.div_sel)
            feas_pkg::DSEL_START:
            begin
                div_a = start_reg;
                div_b = {{(AW-SW){1'b0}}, ss_reg};
            end
            feas_pkg::DSEL_SPB:
            begin
                div_a = {{(AW-BW){1'b0}}, bs_reg};
                div_b = {{(AW-SW){1'b0}}, ss_reg};
            end
            feas_pkg::DSEL_LEN:
            begin
                div_a = len_reg;
                div_b = {{(AW-SW){1'b0}}, ss_reg};
            end
            feas_pkg::DSEL_HEAD:
            begin
                div_a = sec_reg;
                div_b = spb_ext;
            end
            feas_pkg::DSEL_BLK:
            begin
                div_a = cur_reg;
                div_b = spb_ext;
            end
            default:
            begin
                div_a = cur_reg;
                div_b = spb_ext;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        head_next  = head_reg;
        rest_next  = rest_reg;
        spb_next   = spb_reg;
        sec_next   = sec_reg;
        total_next = total_reg;
        oval_next  = oval_reg & out_stall;
        odata_next = odata_reg;
        case (cmd.op)
            feas_pkg::OP_LOAD:
            begin
                // a new request drops any running job
                if (in_data.operation == feas_pkg::OPER_REQUEST)
                begin
                    phase_next = 1'b0;
                    cur_next   = '0;
                    head_next  = '0;
                    rest_next  = '0;
                    spb_next   = '0;
                end
            end
            feas_pkg::OP_SEC:
            begin
                sec_next = div_q;
            end
            feas_pkg::OP_SPB:
            begin
                spb_next = div_q[BW-1:0];
            end
            feas_pkg::OP_TOTAL:
            begin
                total_next = div_q + {{(AW-1){1'b0}}, rem_nz};
            end
            feas_pkg::OP_HEAD:
            begin
                // remainder is below spb, so head_raw fits in BW bits
                if (head_raw >= total_reg)
                    head_next = total_reg[BW-1:0];
                else
                    head_next = head_raw[BW-1:0];
            end
            feas_pkg::OP_COMMIT:
            begin
                oval_next         = 1'b1;
                odata_next.kind   = cmd.kind;
                odata_next.target_index = '0;
                case (cmd.kind)
                    feas_pkg::KIND_UNLOCK:
                    begin
                        phase_next = 1'b1;
                        cur_next   = sec_reg;
                        rest_next  = total_reg - {{(AW-BW){1'b0}}, head_reg};
                    end
                    feas_pkg::KIND_SECTOR:
                    begin
                        odata_next.target_index = cur_reg;
                        cur_next = cur_reg + 1'b1;
                        if (head_reg != '0)
                            head_next = head_reg - 1'b1;
                        else
                            rest_next = rest_reg - 1'b1;
                    end
                    feas_pkg::KIND_BLOCK:
                    begin
                        odata_next.target_index = div_q;
                        cur_next  = cur_reg + spb_ext;
                        rest_next = rest_reg - spb_ext;
                    end
                    default:
                    begin
                        phase_next = 1'b0;
                        cur_next   = '0;
                        head_next  = '0;
                        rest_next  = '0;
                        spb_next   = '0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_reg  <= feas_pkg::CHIP_SIZE_RST;
            ss_reg    <= feas_pkg::SECTOR_SIZE_RST;
            bs_reg    <= feas_pkg::BLOCK_SIZE_RST;
            phase_reg <= 1'b0;
            cur_reg   <= '0;
            head_reg  <= '0;
            rest_reg  <= '0;
            spb_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    feas_pkg::CFG_CHIP_SIZE:   chip_reg <= cfg_data;
                    feas_pkg::CFG_SECTOR_SIZE: ss_reg   <= cfg_data[SW-1:0];
                    feas_pkg::CFG_BLOCK_SIZE:  bs_reg   <= cfg_data[BW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            head_reg  <= head_next;
            rest_reg  <= rest_next;
            spb_reg   <= spb_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == feas_pkg::OP_LOAD)
        begin
            oper_reg  <= in_data.operation;
            start_reg <= in_data.base_addr;
            len_reg   <= in_data.erase_len;
            ok_reg    <= in_data.ack_ok;
        end
        sec_reg   <= sec_next;
        total_reg <= total_next;
        odata_reg <= odata_next;
    end

    always_comb
    begin
        sts.is_ack      = (oper_reg == feas_pkg::OPER_ACK);
        sts.job_busy    = phase_reg;
        sts.ack_ok      = ok_reg;
        sts.range_err   = (sum > chip_reg);
        sts.ss_zero     = (ss_reg == '0);
        sts.div_done    = div_done;
        sts.rem_nz      = rem_nz;
        sts.quot_zero   = (div_q == '0);
        sts.head_nz     = (head_reg != '0);
        sts.rest_gt_spb = (spb_reg != '0) && (rest_reg > spb_ext);
        sts.rest_nz     = (rest_reg != '0);
        sts.out_free    = !oval_reg || !out_stall;
    end

    assign out_valid = oval_reg;
    assign out_data  = odata_reg;

endmodule

>>> rtl/feas_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences checks, divisions and result commits.
// Depends on feas_pkg.
module feas_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  feas_pkg::sts_t    sts,
    output feas_pkg::cmd_t    cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] ST_CHECK     = 4'd1;
    localparam logic [ST_W-1:0] ST_DIV_START = 4'd2;
    localparam logic [ST_W-1:0] ST_DIV_SPB   = 4'd3;
    localparam logic [ST_W-1:0] ST_DIV_LEN   = 4'd4;
    localparam logic [ST_W-1:0] ST_DIV_HEAD  = 4'd5;
    localparam logic [ST_W-1:0] ST_DIV_BLK   = 4'd6;
    localparam logic [ST_W-1:0] ST_EMIT      = 4'd7;

    logic [ST_W-1:0]               state_reg, state_next;
    logic [feas_pkg::KIND_W-1:0]   kind_reg, kind_next;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        cmd.op      = feas_pkg::OP_NONE;
        cmd.kind    = kind_reg;
        cmd.div_go  = 1'b0;
        cmd.div_sel = feas_pkg::DSEL_START;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = feas_pkg::OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.is_ack)
                begin
                    if (!sts.job_busy)
                        state_next = ST_IDLE;
                    else if (!sts.ack_ok)
                    begin
                        kind_next  = feas_pkg::KIND_ERR;
                        state_next = ST_EMIT;
                    end
                    else if (sts.head_nz)
                    begin
                        kind_next  = feas_pkg::KIND_SECTOR;
                        state_next = ST_EMIT;
                    end
                    else if (sts.rest_gt_spb)
                    begin
                        cmd.div_go  = 1'b1;
                        cmd.div_sel = feas_pkg::DSEL_BLK;
                        state_next  = ST_DIV_BLK;
                    end
                    else if (sts.rest_nz)
                    begin
                        kind_next  = feas_pkg::KIND_SECTOR;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        kind_next  = feas_pkg::KIND_OK;
                        state_next = ST_EMIT;
                    end
                end
                else if (sts.range_err || sts.ss_zero)
                begin
                    kind_next  = feas_pkg::KIND_ERR;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = feas_pkg::DSEL_START;
                    state_next  = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                if (sts.div_done)
                begin
                    cmd.op = feas_pkg::OP_SEC;
                    if (sts.rem_nz)
                    begin
                        kind_next  = feas_pkg::KIND_ERR;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.div_go  = 1'b1;
                        cmd.div_sel = feas_pkg::DSEL_SPB;
                        state_next  = ST_DIV_SPB;
                    end
                end
            end
            ST_DIV_SPB:
            begin
                if (sts.div_done)
                begin
                    cmd.op = feas_pkg::OP_SPB;
                    if (sts.quot_zero)
                    begin
                        kind_next  = feas_pkg::KIND_ERR;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.div_go  = 1'b1;
                        cmd.div_sel = feas_pkg::DSEL_LEN;
                        state_next  = ST_DIV_LEN;
                    end
                end
            end
            ST_DIV_LEN:
            begin
                // the head division reads sec and spb, already latched
                if (sts.div_done)
                begin
                    cmd.op      = feas_pkg::OP_TOTAL;
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = feas_pkg::DSEL_HEAD;
                    state_next  = ST_DIV_HEAD;
                end
            end
            ST_DIV_HEAD:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = feas_pkg::OP_HEAD;
                    kind_next  = feas_pkg::KIND_UNLOCK;
                    state_next = ST_EMIT;
                end
            end
            ST_DIV_BLK:
            begin
                if (sts.div_done)
                begin
                    kind_next  = feas_pkg::KIND_BLOCK;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // block number stays in the divider until the commit
                cmd.div_sel = feas_pkg::DSEL_BLK;
                if (sts.out_free)
                begin
                    cmd.op     = feas_pkg::OP_COMMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= feas_pkg::KIND_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule
